// ===== src/smm_pkg.sv =====
// ============================================================================
// smm_pkg
// Shared types and constants of the spectral moment block: the controller
// states and the command and status groups between controller and datapath.
// ============================================================================
package smm_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] CFG_ZERO_OFFSET   = 2'd1;
    localparam logic [1:0] CFG_CHANNEL_STEP  = 2'd2;

    // The square root unit works on a 64-bit radicand, two radicand bits a step.
    localparam int SQ_STEPS = 32;

    typedef enum logic [3:0] {
        S_ACC,
        S_PREP,
        S_EMPTY,
        S_DIVQ,
        S_STQ,
        S_DIVE,
        S_MUL1,
        S_MUL2,
        S_SQ1,
        S_MUL3,
        S_MUL4,
        S_LOAD2,
        S_SQ2,
        S_FIN,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic acc_open;
        logic prep;
        logic div_step;
        logic store_q;
        logic mul1;
        logic mul2;
        logic sq_step;
        logic mul3;
        logic mul4;
        logic load2;
        logic fin;
        logic empty;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic end_accept;
        logic s0_zero;
        logic out_free;
    } t_stat;

endpackage

// ===== src/smm_ctrl.sv =====
// ============================================================================
// smm_ctrl
// Sequencer of the moment block: accumulation phase, the two serial
// divisions, the two square roots and the multiply steps between them.
// ============================================================================
module smm_ctrl import smm_pkg::*; #(
    parameter int DIV_STEPS = 80
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam int CNTW = $clog2(DIV_STEPS);

    t_state            r_state, n_state;
    logic [CNTW-1:0]   r_cnt, n_cnt;
    logic              w_div_done, w_sq_done, w_counting;

    assign w_div_done = (r_cnt == CNTW'(DIV_STEPS - 1));
    assign w_sq_done  = (r_cnt == CNTW'(SQ_STEPS - 1));
    assign w_counting = (r_state == S_DIVQ) || (r_state == S_DIVE) ||
                        (r_state == S_SQ1) || (r_state == S_SQ2);

    // Step counter for the iterative units.
    always_comb begin
        n_cnt = '0;
        if (w_counting) begin
            if (((r_state == S_DIVQ || r_state == S_DIVE) && w_div_done) ||
                ((r_state == S_SQ1 || r_state == S_SQ2) && w_sq_done)) begin
                n_cnt = '0;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_ACC:   if (i_stat.end_accept) n_state = S_PREP;
            S_PREP:  n_state = i_stat.s0_zero ? S_EMPTY : S_DIVQ;
            S_EMPTY: n_state = S_OUT;
            S_DIVQ:  if (w_div_done) n_state = S_STQ;
            S_STQ:   n_state = S_DIVE;
            S_DIVE:  if (w_div_done) n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_SQ1;
            S_SQ1:   if (w_sq_done) n_state = S_MUL3;
            S_MUL3:  n_state = S_MUL4;
            S_MUL4:  n_state = S_LOAD2;
            S_LOAD2: n_state = S_SQ2;
            S_SQ2:   if (w_sq_done) n_state = S_FIN;
            S_FIN:   n_state = S_OUT;
            S_OUT:   if (i_stat.out_free) n_state = S_ACC;
            default: n_state = S_ACC;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_ACC:   o_cmd.acc_open = 1'b1;
            S_PREP:  o_cmd.prep     = 1'b1;
            S_EMPTY: o_cmd.empty    = 1'b1;
            S_DIVQ:  o_cmd.div_step = 1'b1;
            S_STQ:   o_cmd.store_q  = 1'b1;
            S_DIVE:  o_cmd.div_step = 1'b1;
            S_MUL1:  o_cmd.mul1     = 1'b1;
            S_MUL2:  o_cmd.mul2     = 1'b1;
            S_SQ1:   o_cmd.sq_step  = 1'b1;
            S_MUL3:  o_cmd.mul3     = 1'b1;
            S_MUL4:  o_cmd.mul4     = 1'b1;
            S_LOAD2: o_cmd.load2    = 1'b1;
            S_SQ2:   o_cmd.sq_step  = 1'b1;
            S_FIN:   o_cmd.fin      = 1'b1;
            S_OUT:   o_cmd.out_load = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // A result is only moved to the output register when that register can take it.
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("result loaded while output register is occupied");

endmodule

// ===== src/smm_dpath.sv =====
// ============================================================================
// smm_dpath
// Datapath of the moment block: configuration registers, the running sums,
// a bit-serial divider, a digit-serial square root, the multiply steps and
// the output register.
// ============================================================================
module smm_dpath import smm_pkg::*; #(
    parameter int MAX_CHANNELS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic signed [15:0] i_flux_sample,
    input  logic               i_out_stall,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic               o_out_valid,
    output logic [24:0]        o_moment_zero,
    output logic signed [31:0] o_moment_one,
    output logic [30:0]        o_moment_two
);

    localparam int IW  = $clog2(MAX_CHANNELS + 1);
    localparam int HW  = IW - 1;
    localparam int S0W = 15 + IW;
    localparam int S1W = 15 + 2 * IW;
    localparam int S2W = 15 + 3 * IW;
    localparam int DW  = S2W + 32;
    localparam int QW  = IW + 16;
    localparam int EW  = 2 * IW + 32;
    localparam int DDW = QW + 1;
    localparam int PW  = 32 + DDW;
    localparam int CW  = 34 + IW;
    localparam int TW  = QW + 16;

    function automatic logic [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sh7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end else if (x < -64'sh8000_0000) begin
            return 32'h8000_0000;
        end else begin
            return x[31:0];
        end
    endfunction

    // Configuration registers.
    logic [10:0]        r_cfg_cc;
    logic signed [31:0] r_cfg_zo;
    logic signed [31:0] r_cfg_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cc   <= 11'd1;
            r_cfg_zo   <= '0;
            r_cfg_step <= 32'sd65536;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CHANNEL_COUNT: r_cfg_cc   <= i_cfg_data[10:0];
                CFG_ZERO_OFFSET:   r_cfg_zo   <= i_cfg_data;
                CFG_CHANNEL_STEP:  r_cfg_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective channel count: zero acts as one, the count is capped at the maximum.
    logic [IW-1:0] w_n;
    always_comb begin
        if (r_cfg_cc == 11'd0) begin
            w_n = IW'(1);
        end else if (32'(r_cfg_cc) > 32'(MAX_CHANNELS)) begin
            w_n = IW'(MAX_CHANNELS);
        end else begin
            w_n = IW'(r_cfg_cc);
        end
    end

    // Running sums over the spectrum; the channel square is kept incrementally.
    logic [IW-1:0]   r_idx;
    logic [2*IW-1:0] r_zz;
    logic [S0W-1:0]  r_s0;
    logic [S1W-1:0]  r_s1;
    logic [S2W-1:0]  r_s2;
    logic [14:0]     w_f;
    logic [IW-1:0]   w_idx_inc;
    logic [S0W-1:0]  w_s0n;
    logic [S1W-1:0]  w_s1n;
    logic [S2W-1:0]  w_s2n;
    logic            w_accept, w_last;

    assign w_f       = i_flux_sample[15] ? 15'd0 : i_flux_sample[14:0];
    assign w_idx_inc = r_idx + 1'b1;
    assign w_last    = (w_idx_inc >= w_n);
    assign w_accept  = i_in_valid && i_cmd.acc_open;
    assign w_s0n     = r_s0 + S0W'(w_f);
    assign w_s1n     = r_s1 + S1W'(w_f) * S1W'(r_idx);
    assign w_s2n     = r_s2 + S2W'(w_f) * S2W'(r_zz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_zz  <= '0;
            r_s0  <= '0;
            r_s1  <= '0;
            r_s2  <= '0;
        end else if (w_accept) begin
            if (w_last) begin
                r_idx <= '0;
                r_zz  <= '0;
                r_s0  <= '0;
                r_s1  <= '0;
                r_s2  <= '0;
            end else begin
                r_idx <= w_idx_inc;
                r_zz  <= r_zz + (2 * IW)'({r_idx, 1'b1});
                r_s0  <= w_s0n;
                r_s1  <= w_s1n;
                r_s2  <= w_s2n;
            end
        end
    end

    // Snapshot of a finished spectrum for the back end.
    logic [S0W-1:0] r_t0;
    logic [S1W-1:0] r_t1;
    logic [S2W-1:0] r_t2;
    logic [HW-1:0]  r_h;

    always_ff @(posedge i_clk) begin
        if (w_accept && w_last) begin
            r_t0 <= w_s0n;
            r_t1 <= w_s1n;
            r_t2 <= w_s2n;
            r_h  <= w_n[IW-1:1];
        end
    end

    // Restoring divider by the flux sum, one quotient bit per step.
    logic [DW-1:0]  r_dvd;
    logic [S0W:0]   r_rem;
    logic [S0W:0]   w_rem_sh;
    logic           w_rem_ge;

    assign w_rem_sh = {r_rem[S0W-1:0], r_dvd[DW-1]};
    assign w_rem_ge = (w_rem_sh >= {1'b0, r_t0});

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_dvd <= DW'({r_t1, 16'b0});
            r_rem <= '0;
        end else if (i_cmd.store_q) begin
            r_dvd <= DW'({r_t2, 32'b0});
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[DW-2:0], w_rem_ge};
            r_rem <= w_rem_ge ? (w_rem_sh - {1'b0, r_t0}) : w_rem_sh;
        end
    end

    // Square root, one result bit per step.
    logic [63:0] r_sv, r_sres, r_sbit;
    logic [63:0] w_trial, w_rad;
    logic        w_sq_ge;
    logic [QW-1:0] r_q;
    logic [EW-1:0] r_e2, r_qq;
    logic [61:0]   r_tt, r_cc;

    assign w_trial = r_sres + r_sbit;
    assign w_sq_ge = (r_sv >= w_trial);
    assign w_rad   = i_cmd.mul2 ? ((r_e2 > r_qq) ? 64'(r_e2 - r_qq) : 64'd0)
                                : (64'(r_tt) + 64'(r_cc));

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul2 || i_cmd.load2) begin
            r_sv   <= w_rad;
            r_sres <= '0;
            r_sbit <= 64'h4000_0000_0000_0000;
        end else if (i_cmd.sq_step) begin
            r_sv   <= w_sq_ge ? (r_sv - w_trial) : r_sv;
            r_sres <= w_sq_ge ? ((r_sres >> 1) + r_sbit) : (r_sres >> 1);
            r_sbit <= r_sbit >> 2;
        end
    end

    // Multiply steps between the serial units.
    logic signed [DDW-1:0] r_d;
    logic signed [PW-1:0]  r_p;
    logic signed [CW-1:0]  r_c;
    logic [TW-1:0]         r_t;
    logic [CW-1:0]         r_ca;
    logic                  r_sat;
    logic [31:0]           r_m1;
    logic [30:0]           r_m2;
    logic [31:0]           w_step_abs;
    logic [32+QW-1:0]      w_t_full;
    logic signed [63:0]    w_p64, w_pmag, w_c64;

    assign w_step_abs = r_cfg_step[31] ? 32'(-r_cfg_step) : 32'(r_cfg_step);
    assign w_t_full   = (32 + QW)'(w_step_abs) * (32 + QW)'(r_sres[QW-1:0]);
    assign w_p64      = 64'(r_p);
    assign w_pmag     = (w_p64[63] ? -w_p64 : w_p64) >>> 16;
    assign w_c64      = 64'(r_c);

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_c <= CW'(r_cfg_zo) + CW'(r_cfg_step) * CW'(signed'({1'b0, r_h}));
        end
        if (i_cmd.store_q) begin
            r_q <= r_dvd[QW-1:0];
        end
        if (i_cmd.mul1) begin
            r_e2 <= r_dvd[EW-1:0];
            r_qq <= EW'(r_q) * EW'(r_q);
            r_d  <= DDW'(r_q) - DDW'({r_h, 16'b0});
        end
        if (i_cmd.mul2) begin
            r_p <= PW'(r_d) * PW'(r_cfg_step);
        end
        if (i_cmd.mul3) begin
            r_t  <= TW'(w_t_full >> 16);
            r_ca <= r_c[CW-1] ? CW'(-r_c) : CW'(r_c);
            r_m1 <= sat32(w_p64[63] ? -w_pmag : w_pmag);
        end
        if (i_cmd.mul4) begin
            r_sat <= (64'(r_t) >= 64'h8000_0000) || (64'(r_ca) >= 64'h8000_0000);
            r_tt  <= 62'(r_t[30:0]) * 62'(r_t[30:0]);
            r_cc  <= 62'(r_ca[30:0]) * 62'(r_ca[30:0]);
        end
        if (i_cmd.fin) begin
            r_m2 <= (r_sat || (r_sres > 64'h7FFF_FFFF)) ? 31'h7FFF_FFFF : r_sres[30:0];
        end else if (i_cmd.empty) begin
            r_m1 <= sat32(-w_c64);
            r_m2 <= '0;
        end
    end

    // Output register.
    logic        r_ovalid;
    logic [24:0] r_om0;
    logic [31:0] r_om1;
    logic [30:0] r_om2;
    logic [63:0] w_m0_full;

    assign w_m0_full = 64'(r_t0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_om0 <= (w_m0_full > 64'h1FF_FFFF) ? 25'h1FF_FFFF : w_m0_full[24:0];
            r_om1 <= r_m1;
            r_om2 <= r_m2;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_moment_zero = r_om0;
    assign o_moment_one  = r_om1;
    assign o_moment_two  = r_om2;

    assign o_stat.end_accept = w_accept && w_last;
    assign o_stat.s0_zero    = (r_t0 == '0);
    assign o_stat.out_free   = !r_ovalid || !i_out_stall;

    // The divider remainder stays below the divisor after every step.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |=> (r_rem < {1'b0, r_t0}))
        else $error("divider remainder not below flux sum");

    // The root unit always iterates with a single trial bit.
    a_sq_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sq_step |-> $onehot(r_sbit))
        else $error("square root trial bit lost");

    // The sums are cleared once the last channel of a spectrum is taken.
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.end_accept |=> (r_s0 == '0) && (r_idx == '0) && (r_s2 == '0))
        else $error("sums not cleared at end of spectrum");

endmodule

// ===== src/spectral_moment_maps_top.sv =====
// Throughput: one flux beat per cycle within a spectrum; the input stalls while the
// serial divider (one quotient bit per cycle, run twice), the square root unit (run
// twice) and the multiply steps work on the finished spectrum, and until the result
// is taken into the output register.
// Reset: synchronous active-low; clears sums and control, restores register defaults.
// ============================================================================
// spectral_moment_maps_top
// Moments 0, 1 and 2 of a spectral line profile: flux samples of one spectrum
// are summed channel by channel, then divided and rooted in a serial back end.
// ============================================================================
module spectral_moment_maps_top import smm_pkg::*; #(
    parameter int MAX_CHANNELS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_flux_sample,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [24:0]        o_moment_zero,
    output logic signed [31:0] o_moment_one,
    output logic [30:0]        o_moment_two
);

    localparam int IW        = $clog2(MAX_CHANNELS + 1);
    localparam int DIV_STEPS = 47 + 3 * IW;

    t_cmd  w_cmd;
    t_stat w_stat;

    smm_ctrl #(
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    smm_dpath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_flux_sample (i_flux_sample),
        .i_out_stall   (i_out_stall),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_out_valid   (o_out_valid),
        .o_moment_zero (o_moment_zero),
        .o_moment_one  (o_moment_one),
        .o_moment_two  (o_moment_two)
    );

    // Input beats are taken only during the accumulation phase.
    assign o_in_stall = !w_cmd.acc_open;

endmodule
